// ===== rtl/bisection_root_cubic_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Bisection root unit assertion macros
// Shared concurrent assertion forms for the bisection root unit checkers.
// ----------------------------------------------------------------------------
`ifndef BISECTION_ROOT_CUBIC_UNIT_DEFINES_SVH
`define BISECTION_ROOT_CUBIC_UNIT_DEFINES_SVH

// clocked check, off while reset is asserted
`define BRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked check that also holds while reset is asserted
`define BRC_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/brc_pkg.sv =====
// ----------------------------------------------------------------------------
// Bisection root unit package
// Widths, codes and shared types for the cubic bisection root finder.
// ----------------------------------------------------------------------------
`default_nettype none

package brc_pkg;

    localparam int DATA_W        = 32;
    localparam int ITER_W        = 6;
    localparam int STAT_W        = 2;
    localparam int TOL_W         = 31;
    localparam int FRAC_BITS_DEF = 16;
    // cube of a 32-bit magnitude plus sign and headroom
    localparam int WIDE_W        = 3 * DATA_W + 2;

    localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(7);
    localparam logic [ITER_W-1:0] MAX_STEPS = ITER_W'(63);

    localparam logic [STAT_W-1:0] STAT_CONV   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_EXACT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_NOBRK  = 2'd2;

    // result of one evaluation of f(x) = x^3 - x + 1
    typedef struct packed {
        logic done;
        logic zero;
        logic neg;
    } feval_res_t;

endpackage

`default_nettype wire

// ===== rtl/brc_feval.sv =====
// ----------------------------------------------------------------------------
// Cubic sign evaluator
// Exact sign of x^3 - x + 1 in fixed point, using one shared 32x32 multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module brc_feval #(
    parameter int FRAC_BITS = brc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [brc_pkg::DATA_W-1:0]  x,
    output brc_pkg::feval_res_t              res
);
    import brc_pkg::*;

    typedef enum logic [6:0] {
        F_IDLE = 7'b0000001,
        F_SQ   = 7'b0000010,
        F_LO   = 7'b0000100,
        F_HI   = 7'b0001000,
        F_CUBE = 7'b0010000,
        F_SUM  = 7'b0100000,
        F_TEST = 7'b1000000
    } fstate_t;

    localparam int SH_LIN = 2 * FRAC_BITS;
    localparam int SH_ONE = 3 * FRAC_BITS;
    localparam logic [WIDE_W-1:0] ONE_C = {{(WIDE_W-1){1'b0}}, 1'b1} << SH_ONE;

    fstate_t                  state_reg, state_next;
    logic [DATA_W-1:0]        mag_reg;
    logic                     neg_reg;
    logic [WIDE_W-1:0]        k_reg;
    logic [2*DATA_W-1:0]      sq_reg, p0_reg, p1_reg;
    logic [3*DATA_W-1:0]      cube_reg;
    logic [WIDE_W-1:0]        f_reg;

    logic [DATA_W-1:0]        mul_a;
    logic [2*DATA_W-1:0]      product;
    logic [WIDE_W-1:0]        x_wide;
    logic [WIDE_W-1:0]        cube_wide;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            F_SQ:    mul_a = mag_reg;
            F_LO:    mul_a = sq_reg[DATA_W-1:0];
            F_HI:    mul_a = sq_reg[2*DATA_W-1:DATA_W];
            default: mul_a = mag_reg;
        endcase
    end

    assign product   = mul_a * mag_reg;
    assign x_wide    = {{(WIDE_W-DATA_W){x[DATA_W-1]}}, x};
    assign cube_wide = {{(WIDE_W-3*DATA_W){1'b0}}, cube_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:  if (start) state_next = F_SQ;
            F_SQ:    state_next = F_LO;
            F_LO:    state_next = F_HI;
            F_HI:    state_next = F_CUBE;
            F_CUBE:  state_next = F_SUM;
            F_SUM:   state_next = F_TEST;
            F_TEST:  state_next = start ? F_SQ : F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= x[DATA_W-1];
            mag_reg <= x[DATA_W-1] ? (~x + DATA_W'(1)) : x;
            // 2^(3F) - x * 2^(2F)
            k_reg   <= ONE_C - (x_wide << SH_LIN);
        end
        case (state_reg)
            F_SQ:    sq_reg <= product;
            F_LO:    p0_reg <= product;
            F_HI:    p1_reg <= product;
            F_CUBE:  cube_reg <= {p1_reg, {DATA_W{1'b0}}} +
                                 {{DATA_W{1'b0}}, p0_reg};
            F_SUM:   f_reg <= neg_reg ? (k_reg - cube_wide) : (k_reg + cube_wide);
            default: ;
        endcase
    end

    assign res.done = (state_reg == F_TEST);
    assign res.zero = (f_reg == '0);
    assign res.neg  = f_reg[WIDE_W-1];

endmodule

`default_nettype wire

// ===== rtl/bisection_root_cubic_unit.sv =====
// ----------------------------------------------------------------------------
// Bisection root unit
// Finds a root of x^3 - x + 1 on a signed fixed-point interval by bisection.
// ----------------------------------------------------------------------------
// One interval word is taken while s_tready is high; the block then stays busy
// until its result is handed to the output register. Each evaluation of f
// runs through one shared 32x32 multiplier. An item evaluates f at both ends,
// then at the midpoint of each of n <= 33 bisection steps, ending early at an
// exact root; a bracket failure ends after the two end evaluations. A
// finished result may wait in the output register while the next interval
// is accepted. Tolerance is to be written on the cfg channel between items,
// which the block does not enforce; a value of zero acts as one.
`default_nettype none

module bisection_root_cubic_unit #(
    parameter int FRAC_BITS = brc_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // [31:0] lower_bound, [63:32] upper_bound
    input  wire logic [2*brc_pkg::DATA_W-1:0] s_tdata,
    input  wire logic                         s_tvalid,
    output      logic                         s_tready,
    // [31:0] root, [37:32] iterations, [39:38] status
    output      logic [39:0]                  m_tdata,
    output      logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [brc_pkg::TOL_W-1:0]    cfg_data,
    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready
);
    import brc_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_EVAL_A = 7'b0000010,
        ST_EVAL_B = 7'b0000100,
        ST_BISECT = 7'b0001000,
        ST_EVAL_M = 7'b0010000,
        ST_WIDTH  = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    logic [TOL_W-1:0]    tol_reg;
    logic [DATA_W-1:0]   a_reg, b_reg, mid_reg;
    logic [ITER_W-1:0]   steps_reg;
    logic [STAT_W-1:0]   status_reg;
    logic                sa_zero_reg, sa_neg_reg;
    logic [DATA_W-1:0]   out_root_reg;
    logic [ITER_W-1:0]   out_iter_reg;
    logic [STAT_W-1:0]   out_status_reg;
    logic                out_valid_reg;

    feval_res_t          fres;
    logic                ev_start;
    logic [DATA_W-1:0]   ev_x;
    logic                in_acc;
    logic [DATA_W:0]     sum_ab;
    logic [DATA_W-1:0]   mid_val;
    logic signed [DATA_W+1:0] diff, tol_pos, tol_neg;
    logic [TOL_W-1:0]    tol_eff;
    logic                in_tol, no_brk, out_free;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || m_tready;

    // floor((a+b)/2) is an arithmetic shift of the 33-bit sum
    assign sum_ab  = {a_reg[DATA_W-1], a_reg} + {b_reg[DATA_W-1], b_reg};
    assign mid_val = sum_ab[DATA_W:1];

    assign tol_eff = (tol_reg == '0) ? TOL_W'(1) : tol_reg;
    assign diff    = $signed({{2{b_reg[DATA_W-1]}}, b_reg}) -
                     $signed({{2{a_reg[DATA_W-1]}}, a_reg});
    assign tol_pos = $signed({{(DATA_W+2-TOL_W){1'b0}}, tol_eff});
    assign tol_neg = -tol_pos;
    assign in_tol  = (diff <= tol_pos) && (diff >= tol_neg);

    assign no_brk  = sa_zero_reg || fres.zero || (sa_neg_reg == fres.neg);

    always_comb
    begin
        ev_start = 1'b0;
        ev_x     = mid_val;
        case (state_reg)
            ST_IDLE:
            begin
                ev_start = in_acc;
                ev_x     = s_tdata[DATA_W-1:0];
            end
            ST_EVAL_A:
            begin
                ev_start = fres.done;
                ev_x     = b_reg;
            end
            ST_BISECT:
            begin
                ev_start = 1'b1;
                ev_x     = mid_val;
            end
            default: ;
        endcase
    end

    brc_feval #(
        .FRAC_BITS (FRAC_BITS)
    ) u_feval (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ev_start),
        .x     (ev_x),
        .res   (fres)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (in_acc) state_next = ST_EVAL_A;
            ST_EVAL_A: if (fres.done) state_next = ST_EVAL_B;
            ST_EVAL_B: if (fres.done) state_next = no_brk ? ST_DONE : ST_BISECT;
            ST_BISECT: state_next = ST_EVAL_M;
            ST_EVAL_M: if (fres.done) state_next = fres.zero ? ST_DONE : ST_WIDTH;
            ST_WIDTH:  state_next = (in_tol || steps_reg == MAX_STEPS) ? ST_DONE
                                                                    : ST_BISECT;
            ST_DONE:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            tol_reg       <= TOL_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
                tol_reg <= cfg_data;
            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    a_reg      <= s_tdata[DATA_W-1:0];
                    b_reg      <= s_tdata[2*DATA_W-1:DATA_W];
                    steps_reg  <= '0;
                    mid_reg    <= '0;
                    status_reg <= STAT_CONV;
                end
            end
            ST_EVAL_A:
            begin
                if (fres.done)
                begin
                    sa_zero_reg <= fres.zero;
                    sa_neg_reg  <= fres.neg;
                end
            end
            ST_EVAL_B:
            begin
                if (fres.done && no_brk)
                    status_reg <= STAT_NOBRK;
            end
            ST_BISECT:
            begin
                mid_reg   <= mid_val;
                steps_reg <= steps_reg + ITER_W'(1);
            end
            ST_EVAL_M:
            begin
                if (fres.done)
                begin
                    if (fres.zero)
                        status_reg <= STAT_EXACT;
                    else if (fres.neg)
                        a_reg <= mid_reg;
                    else
                        b_reg <= mid_reg;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_root_reg   <= mid_reg;
                    out_iter_reg   <= steps_reg;
                    out_status_reg <= status_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_status_reg, out_iter_reg, out_root_reg};

endmodule

`default_nettype wire

// ===== rtl/brc_checker.sv =====
// ----------------------------------------------------------------------------
// Bisection root unit checker
// Port-level assertions on the bisection root unit, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

`include "bisection_root_cubic_unit_defines.svh"

module brc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tvalid,
    input wire logic        m_tready
);
    import brc_pkg::*;

    `BRC_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "output word changed while stalled")
    `BRC_ASSERT(a_busy_after_accept, s_tvalid && s_tready |=> !s_tready, "ready right after accepting a word")
    `BRC_ASSERT(a_nobrk_zero, m_tvalid && m_tdata[39:38] == STAT_NOBRK |-> m_tdata[37:0] == 38'd0, "no-bracket result has nonzero root or steps")
    `BRC_ASSERT(a_iter_range, m_tvalid && m_tdata[39:38] != STAT_NOBRK |-> m_tdata[37:32] != 6'd0 && m_tdata[37:32] <= 6'd33, "step count out of range")
    `BRC_ASSERT_RST(a_reset_idle, !rst_n |=> !m_tvalid, "output valid during reset")

endmodule

bind bisection_root_cubic_unit brc_checker u_brc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire

// ===== tb/bisection_root_cubic_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Bisection root unit testbench
// Sends interval words to the cubic root finder under several tolerance
// settings and checks every result word against a local bisection predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module bisection_root_cubic_unit_tb;

    import brc_pkg::*;

    // same layout as m_tdata
    typedef struct packed {
        logic [STAT_W-1:0]        status;
        logic [ITER_W-1:0]        iterations;
        logic signed [DATA_W-1:0] root;
    } root_word_t;

    class root_scoreboard;
        logic [TOL_W-1:0] tolerance;
        root_word_t       expected_roots[$];
        int unsigned      mismatches;

        function new();
            tolerance   = TOL_RESET;
            mismatches  = 0;
        endfunction

        // sign of x^3 - x*2^(2F) + 2^(3F) for a raw fixed-point x
        function automatic int cubic_sign(logic signed [33:0] x);
            logic signed [127:0] xw;
            logic signed [127:0] val;
            xw  = x;
            val = xw * xw * xw - (xw <<< (2 * FRAC_BITS_DEF))
                  + (128'sd1 <<< (3 * FRAC_BITS_DEF));
            if (val == 0)
                return 0;
            return (val < 0) ? -1 : 1;
        endfunction

        function automatic void note_interval(logic signed [31:0] lo,
                                              logic signed [31:0] hi);
            logic signed [33:0] a;
            logic signed [33:0] b;
            logic signed [33:0] mid;
            logic signed [33:0] width;
            logic [TOL_W-1:0]   tol_eff;
            int                 sign_lo;
            int                 sign_hi;
            int                 sign_mid;
            int                 steps;
            bit                 done;
            root_word_t         res;
            a       = lo;
            b       = hi;
            sign_lo = cubic_sign(a);
            sign_hi = cubic_sign(b);
            res     = '0;
            if (sign_lo == 0 || sign_hi == 0 || sign_lo == sign_hi)
            begin
                res.status = STAT_NOBRK;
            end
            else
            begin
                tol_eff    = (tolerance == 0) ? TOL_W'(1) : tolerance;
                steps      = 0;
                done       = 0;
                res.status = STAT_CONV;
                mid        = 0;
                while (!done)
                begin
                    mid      = (a + b) >>> 1;   // floor of the half sum
                    steps++;
                    sign_mid = cubic_sign(mid);
                    if (sign_mid == 0)
                    begin
                        res.status = STAT_EXACT;
                        done       = 1;
                    end
                    else
                    begin
                        if (sign_mid > 0)
                            b = mid;
                        else
                            a = mid;
                        width = b - a;
                        if (width < 0)
                            width = -width;
                        if (width <= $signed({3'b000, tol_eff}) || steps >= MAX_STEPS)
                            done = 1;
                    end
                end
                res.root       = mid[31:0];
                res.iterations = ITER_W'(steps);
            end
            expected_roots.push_back(res);
        endfunction

        function automatic void check_result(logic [39:0] word);
            root_word_t got;
            root_word_t want;
            got = word;
            if (expected_roots.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word %h", word);
                return;
            end
            want = expected_roots.pop_front();
            if (got.root !== want.root || got.iterations !== want.iterations
                || got.status !== want.status)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: root %0d/%0d iterations %0d/%0d status %0d/%0d (exp/act)",
                             want.root, got.root, want.iterations, got.iterations,
                             want.status, got.status);
            end
        endfunction

        function automatic int pending();
            return expected_roots.size();
        endfunction
    endclass

    localparam int STALL_LIMIT  = 3000;
    localparam int PHASE_ITEMS  = 190;
    // two adjacent raw values, both just below the real root (about -1.3247)
    localparam logic signed [31:0] ROOT_BELOW = -32'sd86818;
    localparam logic signed [31:0] ROOT_ABOVE = -32'sd86817;
    localparam logic signed [31:0] VAL_MIN    = 32'sh8000_0000;
    localparam logic signed [31:0] VAL_MAX    = 32'sh7FFF_FFFF;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic [63:0]          s_tdata   = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [39:0]          m_tdata;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [TOL_W-1:0]     cfg_data  = '0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;

    bit                   calm      = 0;
    int                   stall_cycles;
    root_scoreboard       roots     = new();

    bisection_root_cubic_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit take_break();
        return !calm && ($urandom_range(99) < 14);
    endfunction

    task automatic send_interval(input logic signed [31:0] lo, input logic signed [31:0] hi);
        @(negedge clk);
        while (take_break())
        begin
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom};
            @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {hi, lo};
        do
            @(posedge clk);
        while (!s_tready);
        roots.note_interval(lo, hi);
    endtask

    task automatic write_tolerance(input logic [TOL_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        roots.tolerance = value;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // drop valid after the last word and let the block drain
    task automatic drain();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (roots.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic logic signed [31:0] clamp32(longint v);
        if (v < longint'(VAL_MIN))
            return VAL_MIN;
        if (v > longint'(VAL_MAX))
            return VAL_MAX;
        return v[31:0];
    endfunction

    // mostly brackets of log-spread width around the root, some swapped,
    // some tight, the rest raw noise
    task automatic pick_interval(output logic signed [31:0] lo, output logic signed [31:0] hi);
        int unsigned  r;
        longint       below;
        longint       above;
        r     = $urandom_range(99);
        below = longint'(ROOT_BELOW) - longint'($urandom >> $urandom_range(31, 1));
        above = longint'(ROOT_ABOVE) + longint'($urandom >> $urandom_range(31, 1));
        if (r < 55)
        begin
            lo = clamp32(below);
            hi = clamp32(above);
        end
        else if (r < 70)
        begin
            lo = clamp32(above);
            hi = clamp32(below);
        end
        else if (r < 80)
        begin
            lo = ROOT_BELOW - $signed({1'b0, 31'($urandom_range(64))});
            hi = ROOT_ABOVE + $signed({1'b0, 31'($urandom_range(64))});
        end
        else
        begin
            lo = $urandom;
            hi = $urandom;
        end
    endtask

    // result side: ready drops at random, sampled on the rising edge
    initial
    begin
        forever
        begin
            @(negedge clk);
            m_tready = !take_break();
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                roots.check_result(m_tdata);
        end
    end

    // watchdog on cycles with no word moving on any channel
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("bisection_root_cubic_unit_tb NOT OK");
        $finish;
    end

    initial
    begin
        logic [TOL_W-1:0]   tol_plan[7];
        logic signed [31:0] lo;
        logic signed [31:0] hi;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset tolerance first
        send_interval(VAL_MIN, VAL_MAX);
        send_interval(VAL_MAX, VAL_MIN);
        send_interval(-32'sd131072, -32'sd65536);
        send_interval(-32'sd65536, -32'sd131072);
        send_interval(32'sd0, 32'sd65536);           // both ends positive
        send_interval(VAL_MIN, -32'sd131072);        // both ends negative
        send_interval(-32'sd131072, -32'sd131072);   // degenerate interval
        send_interval(32'sd0, 32'sd0);
        send_interval(-32'sd1, 32'sd0);
        send_interval(ROOT_BELOW, ROOT_ABOVE);       // both ends below the root: no bracket
        send_interval(ROOT_ABOVE, ROOT_BELOW);
        send_interval(ROOT_BELOW, VAL_MAX);
        send_interval(VAL_MIN, ROOT_ABOVE);
        send_interval(32'sh5555_5555, 32'shAAAA_AAAA);
        drain();

        tol_plan[0] = TOL_W'(1);
        tol_plan[1] = TOL_W'(0);                     // acts as one
        tol_plan[2] = {TOL_W{1'b1}};
        tol_plan[3] = TOL_W'(7);
        tol_plan[4] = TOL_W'($urandom_range(2, 200));
        tol_plan[5] = TOL_W'(65536);
        tol_plan[6] = TOL_W'($urandom);

        for (int p = 0; p < 7; p++)
        begin
            write_tolerance(tol_plan[p]);
            calm = (p == 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                pick_interval(lo, hi);
                send_interval(lo, hi);
            end
            drain();
        end
        calm = 0;

        repeat (300) @(posedge clk);
        if (roots.mismatches == 0 && roots.pending() == 0)
            $display("bisection_root_cubic_unit_tb OK");
        else
            $display("bisection_root_cubic_unit_tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
+incdir+rtl
rtl/brc_pkg.sv
rtl/brc_feval.sv
rtl/bisection_root_cubic_unit.sv
rtl/brc_checker.sv
tb/bisection_root_cubic_unit_tb.sv
